@@ rtl/lzwe_pkg.sv @@
package lzwe_pkg;

   localparam int TABLE_SIZE  = 4096;
   localparam int HASH_SLOTS  = 5003;
   localparam int FIRST_FREE  = 257;
   localparam int START_WIDTH = 9;
   localparam int MAX_WIDTH   = 12;

   localparam int CODE_W  = 12;
   localparam int SLOT_W  = 13;
   localparam int NEXT_W  = 13;
   localparam int KEY_W   = 20;
   localparam int WID_W   = 4;
   localparam int BUF_W   = 20;
   localparam int CNT_W   = 5;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic [WID_W-1:0]  width;
      logic              flush;
   } pack_cmd_type;

endpackage

@@ rtl/lzw_variable_width_encoder_unit.sv @@
// LZW encoder, 9 to 12 bit codes packed LSB-first into bytes. Bytes enter on req_ with
// req_last_byte on the final byte of a stream; packed bytes leave on rsp_, with
// rsp_end_of_stream on the zero-padded last byte. A two-item input queue lets bytes arrive
// while the dictionary engine works. A byte settled by its first hash probe is taken,
// hashed (reciprocal multiply, then remainders), its slot read and tested, then its entry
// compared on a hit or its code emitted on a miss, and finished; every extra collision
// repeats the slot read, slot test and entry compare. The first byte of a stream goes
// from being taken straight to the finish. A miss or a final byte also waits while the
// packer still holds a whole byte or is flushing. After reset and after every stream all
// 5003 hash store slots are cleared, during which no byte is taken by the engine. Output
// bytes drain one per cycle from the packer's output register while rsp_ready stays high.
module lzw_variable_width_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_stream
);

   lzwe_pkg::item_type     head;
   lzwe_pkg::pack_cmd_type cmd;
   logic                   pop;
   logic                   pack_busy;

   lzwe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .pop           (pop),
      .head          (head)
   );

   lzwe_dict u_dict (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .cmd       (cmd),
      .pack_busy (pack_busy)
   );

   lzwe_packer u_packer (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .busy              (pack_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

endmodule

@@ rtl/lzwe_front.sv @@
module lzwe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                pop,
   output lzwe_pkg::item_type  head
);

   logic [8:0] q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, do_pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != 2'd0);

   assign head.valid     = (count_ff != 2'd0);
   assign head.data_byte = q_ff[rd_ptr_ff][8:1];
   assign head.last_byte = q_ff[rd_ptr_ff][0];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= {req_data_byte, req_last_byte};
      end
   end

endmodule

@@ rtl/lzwe_packer.sv @@
module lzwe_packer (
   input  logic                    clock,
   input  logic                    reset,
   input  lzwe_pkg::pack_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_end_of_stream
);

   logic [lzwe_pkg::BUF_W-1:0]  buf_ff, buf_in;
   logic [lzwe_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        flush_ff, flush_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_eos_ff, rsp_eos_in;
   logic                        take_out;
   logic [lzwe_pkg::CODE_W-1:0] mask, masked;

   assign busy = (cnt_ff >= lzwe_pkg::CNT_W'(8)) || (flush_ff && (cnt_ff != '0));
   assign take_out = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_end_of_stream = rsp_eos_ff;

   always_comb begin
      mask   = {lzwe_pkg::CODE_W{1'b1}} >> (lzwe_pkg::WID_W'(lzwe_pkg::MAX_WIDTH) - cmd.width);
      masked = cmd.code & mask;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      flush_in     = flush_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_eos_in   = rsp_eos_ff;
      if (busy) begin
         if (take_out) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = buf_ff[7:0];
            rsp_eos_in   = flush_ff && (cnt_ff <= lzwe_pkg::CNT_W'(8));
            buf_in       = buf_ff >> 8;
            cnt_in       = (cnt_ff >= lzwe_pkg::CNT_W'(8)) ? cnt_ff - lzwe_pkg::CNT_W'(8) : '0;
            if (rsp_eos_in) begin
               flush_in = 1'b0;
            end
         end
      end else begin
         if (take_out) begin
            rsp_valid_in = 1'b0;
         end
         if (cmd.valid) begin
            buf_in   = buf_ff | (lzwe_pkg::BUF_W'(masked) << cnt_ff);
            cnt_in   = cnt_ff + lzwe_pkg::CNT_W'(cmd.width);
            flush_in = cmd.flush;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_eos_ff  <= rsp_eos_in;
   end

endmodule

@@ rtl/lzwe_dict.sv @@
module lzwe_dict (
   input  logic                    clock,
   input  logic                    reset,
   input  lzwe_pkg::item_type      head,
   output logic                    pop,
   output lzwe_pkg::pack_cmd_type  cmd,
   input  logic                    pack_busy
);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_WAIT     = 4'd1;
   localparam logic [3:0] ST_HASH     = 4'd2;
   localparam logic [3:0] ST_SLOT_RD  = 4'd3;
   localparam logic [3:0] ST_SLOT_CHK = 4'd4;
   localparam logic [3:0] ST_ENT_CHK  = 4'd5;
   localparam logic [3:0] ST_MISS     = 4'd6;
   localparam logic [3:0] ST_FINISH   = 4'd7;
   localparam logic [3:0] ST_REM      = 4'd8;

   localparam int SW = lzwe_pkg::SLOT_W;
   localparam int CW = lzwe_pkg::CODE_W;
   localparam int NW = lzwe_pkg::NEXT_W;
   localparam int KW = lzwe_pkg::KEY_W;
   localparam int WW = lzwe_pkg::WID_W;

   localparam logic [31:0] RCP1 = 32'((64'd1 << 32) / lzwe_pkg::HASH_SLOTS);
   localparam logic [31:0] RCP2 = 32'((64'd1 << 32) / (lzwe_pkg::HASH_SLOTS - 2));

   logic [SW-1:0]    hash_mem [lzwe_pkg::HASH_SLOTS];
   logic [CW+7:0]    ent_mem  [lzwe_pkg::TABLE_SIZE];
   logic [SW-1:0]    slot_q_ff;
   logic [CW+7:0]    ent_q_ff;

   logic [3:0]       state_ff, state_in;
   logic [SW-1:0]    clr_addr_ff, clr_addr_in;
   logic [7:0]       ch_ff, ch_in;
   logic             last_ff, last_in;
   logic [CW-1:0]    cur_ff, cur_in;
   logic             have_ff, have_in;
   logic [NW-1:0]    nf_ff, nf_in;
   logic [WW-1:0]    width_ff, width_in;
   logic             frozen_ff, frozen_in;
   logic [KW-1:0]    key_ff, key_in;
   logic [KW-1:0]    q1_ff, q1_in, q2_ff, q2_in;
   logic [KW+31:0]   p1, p2;
   logic [KW-1:0]    r1, r2, r1c, r2c;
   logic [SW-1:0]    h_ff, h_in, step_ff, step_in, k_ff, k_in;
   logic [SW:0]      h_sum;
   logic             slot_ok_ff, slot_ok_in;
   logic [NW-1:0]    limit;
   logic             hw_en, ew_en;
   logic [SW-1:0]    hw_addr, hw_data;

   always_comb begin
      p1    = (KW+32)'(key_ff) * (KW+32)'(RCP1);
      p2    = (KW+32)'(key_ff) * (KW+32)'(RCP2);
      r1    = key_ff - q1_ff * KW'(lzwe_pkg::HASH_SLOTS);
      r2    = key_ff - q2_ff * KW'(lzwe_pkg::HASH_SLOTS - 2);
      r1c   = (r1 >= KW'(lzwe_pkg::HASH_SLOTS)) ? r1 - KW'(lzwe_pkg::HASH_SLOTS) : r1;
      r2c   = (r2 >= KW'(lzwe_pkg::HASH_SLOTS - 2)) ? r2 - KW'(lzwe_pkg::HASH_SLOTS - 2) : r2;
      h_sum = {1'b0, h_ff} + {1'b0, step_ff};
      limit = NW'(1) << width_ff;
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      ch_in       = ch_ff;
      last_in     = last_ff;
      cur_in      = cur_ff;
      have_in     = have_ff;
      nf_in       = nf_ff;
      width_in    = width_ff;
      frozen_in   = frozen_ff;
      key_in      = key_ff;
      q1_in       = q1_ff;
      q2_in       = q2_ff;
      h_in        = h_ff;
      step_in     = step_ff;
      k_in        = k_ff;
      slot_ok_in  = slot_ok_ff;
      pop         = 1'b0;
      cmd.valid   = 1'b0;
      cmd.code    = cur_ff;
      cmd.width   = width_ff;
      cmd.flush   = 1'b0;
      hw_en       = 1'b0;
      hw_addr     = h_ff;
      hw_data     = SW'(nf_ff);
      ew_en       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            hw_en   = 1'b1;
            hw_addr = clr_addr_ff;
            hw_data = '0;
            if (clr_addr_ff == SW'(lzwe_pkg::HASH_SLOTS - 1)) begin
               state_in = ST_WAIT;
            end else begin
               clr_addr_in = clr_addr_ff + SW'(1);
            end
         end
         ST_WAIT: begin
            if (head.valid) begin
               pop     = 1'b1;
               ch_in   = head.data_byte;
               last_in = head.last_byte;
               if (!have_ff) begin
                  cur_in   = CW'(head.data_byte);
                  have_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  key_in   = {cur_ff, head.data_byte};
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            q1_in    = p1[KW+31:32];
            q2_in    = p2[KW+31:32];
            state_in = ST_REM;
         end
         ST_REM: begin
            h_in     = r1c[SW-1:0];
            step_in  = r2c[SW-1:0] + SW'(1);
            k_in     = '0;
            state_in = ST_SLOT_RD;
         end
         ST_SLOT_RD: begin
            state_in = ST_SLOT_CHK;
         end
         ST_SLOT_CHK: begin
            if (slot_q_ff == '0) begin
               slot_ok_in = 1'b1;
               state_in   = ST_MISS;
            end else begin
               state_in = ST_ENT_CHK;
            end
         end
         ST_ENT_CHK: begin
            if (ent_q_ff == {cur_ff, ch_ff}) begin
               cur_in   = slot_q_ff[CW-1:0];
               state_in = ST_FINISH;
            end else if (k_ff == SW'(lzwe_pkg::HASH_SLOTS - 1)) begin
               slot_ok_in = 1'b0;
               state_in   = ST_MISS;
            end else begin
               k_in = k_ff + SW'(1);
               h_in = (h_sum >= (SW+1)'(lzwe_pkg::HASH_SLOTS))
                    ? SW'(h_sum - (SW+1)'(lzwe_pkg::HASH_SLOTS)) : h_sum[SW-1:0];
               state_in = ST_SLOT_RD;
            end
         end
         ST_MISS: begin
            cmd.valid = 1'b1;
            if (!pack_busy) begin
               if (!frozen_ff) begin
                  if (slot_ok_ff && (nf_ff < NW'(lzwe_pkg::TABLE_SIZE)) &&
                      ((nf_ff < limit) || (width_ff < WW'(lzwe_pkg::MAX_WIDTH)))) begin
                     hw_en = 1'b1;
                     ew_en = 1'b1;
                     nf_in = nf_ff + NW'(1);
                     if ((nf_in > limit) && (width_ff < WW'(lzwe_pkg::MAX_WIDTH))) begin
                        width_in = width_ff + WW'(1);
                     end
                  end else begin
                     frozen_in = 1'b1;
                  end
               end
               cur_in   = CW'(ch_ff);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_WAIT;
            end else begin
               cmd.valid = 1'b1;
               cmd.flush = 1'b1;
               if (!pack_busy) begin
                  cur_in      = '0;
                  have_in     = 1'b0;
                  nf_in       = NW'(lzwe_pkg::FIRST_FREE);
                  width_in    = WW'(lzwe_pkg::START_WIDTH);
                  frozen_in   = 1'b0;
                  clr_addr_in = '0;
                  state_in    = ST_CLEAR;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         cur_ff      <= '0;
         have_ff     <= 1'b0;
         nf_ff       <= NW'(lzwe_pkg::FIRST_FREE);
         width_ff    <= WW'(lzwe_pkg::START_WIDTH);
         frozen_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         cur_ff      <= cur_in;
         have_ff     <= have_in;
         nf_ff       <= nf_in;
         width_ff    <= width_in;
         frozen_ff   <= frozen_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      last_ff    <= last_in;
      key_ff     <= key_in;
      q1_ff      <= q1_in;
      q2_ff      <= q2_in;
      h_ff       <= h_in;
      step_ff    <= step_in;
      k_ff       <= k_in;
      slot_ok_ff <= slot_ok_in;
   end

   always_ff @(posedge clock) begin
      if (hw_en) begin
         hash_mem[hw_addr] <= hw_data;
      end
      slot_q_ff <= hash_mem[h_ff];
   end

   always_ff @(posedge clock) begin
      if (ew_en) begin
         ent_mem[nf_ff[CW-1:0]] <= {cur_ff, ch_ff};
      end
      ent_q_ff <= ent_mem[slot_q_ff[CW-1:0]];
   end

endmodule

@@ rtl/lzwe_checker.sv @@
module lzwe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_end_of_stream
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("req_valid dropped while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_end_of_stream))
      else $error("rsp payload changed while stalled");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("bad state after reset");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset, 2) |-> !rsp_valid)
      else $error("item out during store clear");

endmodule

bind lzw_variable_width_encoder_unit lzwe_checker u_lzwe_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_end_of_stream (rsp_end_of_stream)
);
